/* hdl/bgs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgs_pkg
// shared types and constants of the battery gauge smoother
// ----------------------------------------------------------------------------
package bgs_pkg;

    localparam int TablePoints = 11;

    localparam logic [6:0] ChgLowVal  = 7'd30;
    localparam logic [6:0] ChgFairVal = 7'd65;
    localparam logic [6:0] ChgHighVal = 7'd85;

    localparam logic [2:0] CfgConfirm  = 3'd0;
    localparam logic [2:0] CfgJumpThr  = 3'd1;
    localparam logic [2:0] CfgJumpTol  = 3'd2;
    localparam logic [2:0] CfgEmpty    = 3'd3;
    localparam logic [2:0] CfgLow      = 3'd4;
    localparam logic [2:0] CfgNormal   = 3'd5;
    localparam logic [2:0] CfgFair     = 3'd6;
    localparam logic [2:0] CfgHigh     = 3'd7;

    typedef enum logic [2:0] {
        t_idle,
        t_sort,
        t_seg,
        t_div,
        t_smooth,
        t_out
    } t_state;

    // table segment lower voltage, indexed by segment
    function automatic logic [12:0] volt_at(input logic [3:0] k);
        case (k)
            4'd0:    volt_at = 13'd3000;
            4'd1:    volt_at = 13'd3300;
            4'd2:    volt_at = 13'd3500;
            4'd3:    volt_at = 13'd3600;
            4'd4:    volt_at = 13'd3700;
            4'd5:    volt_at = 13'd3800;
            4'd6:    volt_at = 13'd3900;
            4'd7:    volt_at = 13'd4000;
            4'd8:    volt_at = 13'd4100;
            4'd9:    volt_at = 13'd4150;
            default: volt_at = 13'd4200;
        endcase
    endfunction

endpackage
`default_nettype wire

/* hdl/battery_gauge_smoother_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_gauge_smoother_unit
// battery percent from three voltage samples with step and jump smoothing
// ----------------------------------------------------------------------------
// usage
//  - input item on s_axis: tdata holds sample_a, sample_b, sample_c
//    (12 bits each); tuser holds charger_present
//  - result item on m_axis: tdata holds raw_percent, shown_percent,
//    battery_class, charge_class, class_changed, cut_charge_request;
//    tuser holds measured
//  - config: write enable, index 0..7, 7-bit data, only while idle
// timing
//  - one item at a time; a measured item passes from accept to the next
//    accept through the median pick, the table segment walk, the
//    bit-serial restoring divide of the interpolation, smoothing, the
//    result register and idle
//  - a reading below or above the table skips the divide
//  - a skipped charging item goes from accept straight to the result register
//  - the result register holds until taken; s_axis_tready is low until
//    the held result is accepted
// reset
//  - registers return to their reset values, first reading pending
// ----------------------------------------------------------------------------
module battery_gauge_smoother_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_a[11:0], sample_b[23:12], sample_c[35:24], zero fill
    input  wire  [39:0] s_axis_tdata,
    // charger_present
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // raw_percent[6:0], shown_percent[13:7], battery_class[16:14],
    // charge_class[18:17], class_changed[19], cut_charge_request[20]
    output logic [23:0] m_axis_tdata,
    // measured
    output logic        m_axis_tuser,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [6:0]  i_cfg_data
);

    // config registers
    logic [3:0] r_confirm;
    logic [6:0] r_thr, r_tol, r_lim0, r_lim1, r_lim2, r_lim3, r_lim4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm <= 4'd3; r_thr <= 7'd5; r_tol <= 7'd1;
            r_lim0 <= 7'd5; r_lim1 <= 7'd30; r_lim2 <= 7'd45;
            r_lim3 <= 7'd65; r_lim4 <= 7'd85;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bgs_pkg::CfgConfirm: r_confirm <= i_cfg_data[3:0];
                bgs_pkg::CfgJumpThr: r_thr  <= i_cfg_data;
                bgs_pkg::CfgJumpTol: r_tol  <= i_cfg_data;
                bgs_pkg::CfgEmpty:   r_lim0 <= i_cfg_data;
                bgs_pkg::CfgLow:     r_lim1 <= i_cfg_data;
                bgs_pkg::CfgNormal:  r_lim2 <= i_cfg_data;
                bgs_pkg::CfgFair:    r_lim3 <= i_cfg_data;
                bgs_pkg::CfgHigh:    r_lim4 <= i_cfg_data;
            endcase
        end
    end

    bgs_pkg::t_state r_state, n_state;
    logic [11:0] r_a, r_b, r_c;
    logic        r_chg;
    logic [1:0]  r_cnt;
    logic [3:0]  r_seg;
    logic [12:0] r_mv;
    logic [8:0]  r_rem;    // partial remainder of the divide
    logic [6:0]  r_quo;
    logic [8:0]  r_div;
    logic [3:0]  r_bit;
    logic [6:0]  r_pct;
    // smoothing state
    logic [6:0]  r_shown, r_jval;
    logic [3:0]  r_ccnt;
    logic        r_jpend, r_first, r_skip;
    logic [2:0]  r_last, r_blev;
    logic [1:0]  r_clev;
    logic        r_changed, r_cut, r_meas;

    // median pick: one compare per cycle
    logic [11:0] w_lo, w_hi;
    always_comb begin
        w_lo = (r_a < r_b) ? r_a : r_b;
        w_hi = (r_a < r_b) ? r_b : r_a;
    end

    // segment walk
    logic [12:0] w_vk, w_vk1, w_span, w_off, w_dvd;
    logic [3:0]  w_seg1;
    always_comb begin
        w_seg1 = r_seg + 4'd1;
        w_vk   = bgs_pkg::volt_at(r_seg);
        w_vk1  = bgs_pkg::volt_at(w_seg1);
        w_span = w_vk1 - w_vk;
        w_off  = r_mv - w_vk;
        // 10 * (mv - vk), at most 3000
        w_dvd  = {w_off[9:0], 3'd0} + {w_off[11:0], 1'b0};
    end

    // restoring divide step: 10*(mv-vk) / span, quotient at most 10
    logic [10:0] w_trial;
    always_comb w_trial = {1'b0, r_rem, r_mv[12]} - {2'd0, r_div};

    // smoothing of one reading
    logic [6:0] w_s0, w_s1, w_s2, w_dj, w_dv, w_jv;
    logic [3:0] w_c1, w_c2;
    logic       w_move, w_jp;
    logic [2:0] w_cls;
    logic [1:0] w_clev;
    always_comb begin
        w_s0 = r_first ? r_pct : r_shown;
        w_move = (!r_chg && r_pct < w_s0) || (r_chg && r_pct > w_s0);
        w_c1 = r_first ? 4'd0 : r_ccnt;
        w_c1 = w_c1 + 4'd1;
        w_s1 = w_s0;
        w_c2 = 4'd0;
        if (w_move) begin
            if (w_c1 >= r_confirm) begin
                w_c2 = 4'd0;
                w_s1 = r_chg ? w_s0 + 7'd1 : w_s0 - 7'd1;
            end else begin
                w_c2 = w_c1;
            end
        end
        w_dv = (r_pct > w_s1) ? r_pct - w_s1 : w_s1 - r_pct;
        w_dj = (r_pct > r_jval) ? r_pct - r_jval : r_jval - r_pct;
        w_s2 = w_s1; w_jv = r_jval; w_jp = 1'b0;
        if (w_dv >= r_thr) begin
            if (r_jpend && w_dj <= r_tol) begin
                w_s2 = r_pct;
            end else begin
                w_jv = r_pct; w_jp = 1'b1;
            end
        end
        if (w_s2 <= r_lim0) w_cls = 3'd0;
        else if (w_s2 <= r_lim1) w_cls = 3'd1;
        else if (w_s2 <= r_lim2) w_cls = 3'd2;
        else if (w_s2 <= r_lim3) w_cls = 3'd3;
        else if (w_s2 <= r_lim4) w_cls = 3'd4;
        else w_cls = 3'd5;
        w_clev = r_clev;
        if (r_chg) begin
            if (w_s2 <= bgs_pkg::ChgLowVal) w_clev = 2'd0;
            else if (w_s2 <= bgs_pkg::ChgFairVal) w_clev = 2'd1;
            else if (w_s2 <= bgs_pkg::ChgHighVal) w_clev = 2'd2;
            else w_clev = 2'd3;
        end
    end

    // next state
    logic w_acc;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bgs_pkg::t_idle:   if (w_acc) n_state = (s_axis_tuser && r_skip) ?
                                   bgs_pkg::t_out : bgs_pkg::t_sort;
            bgs_pkg::t_sort:   if (r_cnt == 2'd2) n_state = bgs_pkg::t_seg;
            bgs_pkg::t_seg:    if (r_mv < bgs_pkg::volt_at(4'd0) ||
                                   r_mv > bgs_pkg::volt_at(4'd10))
                                   n_state = bgs_pkg::t_smooth;
                               else if (r_mv <= w_vk1 ||
                                   r_seg == 4'(bgs_pkg::TablePoints - 2))
                                   n_state = bgs_pkg::t_div;
            bgs_pkg::t_div:    if (r_bit == 4'd0) n_state = bgs_pkg::t_smooth;
            bgs_pkg::t_smooth: n_state = bgs_pkg::t_out;
            default:           if (m_axis_tready) n_state = bgs_pkg::t_idle;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == bgs_pkg::t_idle);
        m_axis_tvalid = (r_state == bgs_pkg::t_out);
        m_axis_tuser  = r_meas;
        m_axis_tdata  = {3'd0, r_cut, r_changed, r_clev, r_blev, r_shown,
                         r_meas ? r_pct : 7'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgs_pkg::t_idle;
            r_shown <= 7'd0; r_ccnt <= 4'd0; r_jval <= 7'd0;
            r_jpend <= 1'b0; r_first <= 1'b1; r_skip <= 1'b0;
            r_last <= 3'd7; r_blev <= 3'd0; r_clev <= 2'd0;
            r_meas <= 1'b0; r_changed <= 1'b0; r_cut <= 1'b0;
            r_rem <= 9'd0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                bgs_pkg::t_idle: if (w_acc) begin
                    r_a <= s_axis_tdata[11:0];
                    r_b <= s_axis_tdata[23:12];
                    r_c <= s_axis_tdata[35:24];
                    r_chg <= s_axis_tuser;
                    r_cnt <= 2'd0;
                    r_seg <= 4'd0;
                    if (s_axis_tuser && r_skip) begin
                        r_skip <= 1'b0; r_meas <= 1'b0;
                        r_changed <= 1'b0; r_cut <= 1'b0;
                    end else begin
                        r_skip <= s_axis_tuser;
                    end
                end
                bgs_pkg::t_sort: begin
                    // high of a and b, then low of that and c, then high of
                    // that and the low of a and b gives the median
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd0) begin
                        r_a <= w_hi; r_b <= r_c; r_c <= w_lo;
                    end else if (r_cnt == 2'd1) begin
                        r_a <= w_lo; r_b <= r_c;
                    end else begin
                        r_mv <= {w_hi, 1'b0};
                    end
                end
                bgs_pkg::t_seg: begin
                    if (r_mv < bgs_pkg::volt_at(4'd0)) r_pct <= 7'd0;
                    else if (r_mv > bgs_pkg::volt_at(4'd10)) r_pct <= 7'd100;
                    else if (r_mv <= w_vk1 ||
                             r_seg == 4'(bgs_pkg::TablePoints - 2)) begin
                        r_rem <= 9'd0;
                        r_quo <= 7'd0;
                        r_div <= w_span[8:0];
                        r_bit <= 4'd12;
                        // dividend 10*(mv-vk) shifts out of r_mv msb first
                        r_mv  <= w_dvd;
                        r_pct <= 7'({r_seg, 3'd0} + {r_seg, 1'b0});
                    end else begin
                        r_seg <= w_seg1;
                    end
                end
                bgs_pkg::t_div: begin
                    r_bit <= r_bit - 4'd1;
                    r_mv  <= {r_mv[11:0], 1'b0};
                    if (!w_trial[10]) begin
                        r_rem <= w_trial[8:0];
                        r_quo <= {r_quo[5:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[7:0], r_mv[12]};
                        r_quo <= {r_quo[5:0], 1'b0};
                    end
                    // last quotient bit: add the fraction to the segment base
                    if (r_bit == 4'd0)
                        r_pct <= r_pct + {r_quo[5:0], ~w_trial[10]};
                end
                bgs_pkg::t_smooth: begin
                    r_first <= 1'b0;
                    r_shown <= w_s2; r_ccnt <= w_c2;
                    r_jval <= w_jv; r_jpend <= w_jp;
                    r_blev <= w_cls; r_last <= w_cls;
                    r_changed <= (w_cls != r_last);
                    r_clev <= w_clev;
                    r_cut <= r_chg && (w_clev > 2'd1);
                    r_meas <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

/* tb/battery_gauge_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_gauge_checker
// watches the item and config channels of the gauge smoother, predicts every
// result item from its own copy of state and registers, and compares
// ----------------------------------------------------------------------------
module battery_gauge_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [39:0] s_axis_tdata,
    input  wire         s_axis_tuser,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [23:0] m_axis_tdata,
    input  wire         m_axis_tuser,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [6:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [2:0] ClsEmpty  = 3'd0;
    localparam logic [2:0] ClsLow    = 3'd1;
    localparam logic [2:0] ClsNormal = 3'd2;
    localparam logic [2:0] ClsFair   = 3'd3;
    localparam logic [2:0] ClsHigh   = 3'd4;
    localparam logic [2:0] ClsFull   = 3'd5;
    localparam logic [2:0] ClsNone   = 3'd7;

    typedef struct packed {
        logic       measured;
        logic [6:0] raw;
        logic [6:0] shown;
        logic [2:0] bcls;
        logic [1:0] ccls;
        logic       changed;
        logic       cut;
    } t_gauge;

    // table corners in mV after the divider
    int volt_pts [11] = '{3000, 3300, 3500, 3600, 3700, 3800, 3900, 4000, 4100, 4150, 4200};

    logic [3:0] reg_confirm;
    logic [6:0] reg_thr, reg_tol, reg_empty, reg_low, reg_normal, reg_fair, reg_high;

    int         shown, counter, jump_val, last_cls, bat_lvl, chg_lvl;
    bit         jump_pend, first_pend, skip;

    t_gauge     gauge_queue [$];

    assign o_pending = gauge_queue.size();

    function automatic int absd(input int x, input int y);
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic t_gauge gauge_next(input int a, input int b, input int c,
                                          input bit chg);
        int     hi, lo, mv, k, pct, cls;
        bit     chgd;
        t_gauge r;
        r = '0;
        chgd = 0;
        if (chg && skip) begin
            skip = 0;
            r.shown = shown[6:0];
            r.bcls = bat_lvl[2:0];
            r.ccls = chg_lvl[1:0];
            return r;
        end
        skip = chg;
        hi = (a > b) ? a : b;
        hi = (c > hi) ? c : hi;
        lo = (a < b) ? a : b;
        lo = (c < lo) ? c : lo;
        mv = (a + b + c - hi - lo) * 2;
        if (mv < volt_pts[0]) pct = 0;
        else if (mv > volt_pts[10]) pct = 100;
        else begin
            k = 0;
            while (k < 9 && !(mv >= volt_pts[k] && mv <= volt_pts[k + 1])) k++;
            pct = 10 * k + ((mv - volt_pts[k]) * 10) / (volt_pts[k + 1] - volt_pts[k]);
            if (pct > 100) pct = 100;
        end
        // first reading seeds the shown value
        if (first_pend) begin
            first_pend = 0;
            counter = 0;
            shown = pct;
        end
        if ((!chg && pct < shown) || (chg && pct > shown)) begin
            counter = (counter + 1) & 15;
            if (counter >= reg_confirm) begin
                counter = 0;
                shown = chg ? shown + 1 : shown - 1;
            end
        end else begin
            counter = 0;
        end
        if (absd(pct, shown) >= reg_thr) begin
            if (jump_pend && absd(pct, jump_val) <= reg_tol) begin
                shown = pct;
                jump_pend = 0;
            end else begin
                jump_val = pct;
                jump_pend = 1;
            end
        end else begin
            jump_pend = 0;
        end
        if (shown <= reg_empty) cls = ClsEmpty;
        else if (shown <= reg_low) cls = ClsLow;
        else if (shown <= reg_normal) cls = ClsNormal;
        else if (shown <= reg_fair) cls = ClsFair;
        else if (shown <= reg_high) cls = ClsHigh;
        else cls = ClsFull;
        bat_lvl = cls;
        if (cls != last_cls) begin
            chgd = 1;
            last_cls = cls;
        end
        if (chg) begin
            if (shown <= bgs_pkg::ChgLowVal) chg_lvl = 0;
            else if (shown <= bgs_pkg::ChgFairVal) chg_lvl = 1;
            else if (shown <= bgs_pkg::ChgHighVal) chg_lvl = 2;
            else chg_lvl = 3;
        end
        r.measured = 1;
        r.raw = pct[6:0];
        r.shown = shown[6:0];
        r.bcls = bat_lvl[2:0];
        r.ccls = chg_lvl[1:0];
        r.changed = chgd;
        r.cut = skip && chg_lvl > 1;
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_gauge g, w;
        if (!i_rst_n) begin
            reg_confirm = 4'd3; reg_thr = 7'd5; reg_tol = 7'd1;
            reg_empty = 7'd5; reg_low = 7'd30; reg_normal = 7'd45;
            reg_fair = 7'd65; reg_high = 7'd85;
            shown = 0; counter = 0; jump_val = 0;
            jump_pend = 0; first_pend = 1; skip = 0;
            last_cls = ClsNone; bat_lvl = 0; chg_lvl = 0;
            gauge_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bgs_pkg::CfgConfirm: reg_confirm = i_cfg_data[3:0];
                    bgs_pkg::CfgJumpThr: reg_thr = i_cfg_data;
                    bgs_pkg::CfgJumpTol: reg_tol = i_cfg_data;
                    bgs_pkg::CfgEmpty:   reg_empty = i_cfg_data;
                    bgs_pkg::CfgLow:     reg_low = i_cfg_data;
                    bgs_pkg::CfgNormal:  reg_normal = i_cfg_data;
                    bgs_pkg::CfgFair:    reg_fair = i_cfg_data;
                    bgs_pkg::CfgHigh:    reg_high = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                gauge_queue.push_back(gauge_next(int'(s_axis_tdata[11:0]),
                                                 int'(s_axis_tdata[23:12]),
                                                 int'(s_axis_tdata[35:24]),
                                                 s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready) begin
                g.measured = m_axis_tuser;
                g.raw = m_axis_tdata[6:0];
                g.shown = m_axis_tdata[13:7];
                g.bcls = m_axis_tdata[16:14];
                g.ccls = m_axis_tdata[18:17];
                g.changed = m_axis_tdata[19];
                g.cut = m_axis_tdata[20];
                if (gauge_queue.size() == 0) begin
                    report("unexpected item", 0, 0);
                end else begin
                    w = gauge_queue.pop_front();
                    if (g.measured != w.measured) report("measured", g.measured, w.measured);
                    if (g.raw != w.raw) report("raw_percent", g.raw, w.raw);
                    if (g.shown != w.shown) report("shown_percent", g.shown, w.shown);
                    if (g.bcls != w.bcls) report("battery_class", g.bcls, w.bcls);
                    if (g.ccls != w.ccls) report("charge_class", g.ccls, w.ccls);
                    if (g.changed != w.changed) report("class_changed", g.changed, w.changed);
                    if (g.cut != w.cut) report("cut_charge_request", g.cut, w.cut);
                end
            end
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the gauge smoother with directed and random sample items under
// several register settings, with random idling on both channels
// ----------------------------------------------------------------------------
module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [6:0]  i_cfg_data;

    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          calm;       // no idling on either side while set
    bit          hold_req;   // receiver takes one long hold-off
    int          level;      // mV level the well-formed items wander around

    battery_gauge_smoother_unit dut (.*);

    battery_gauge_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles without any accepted item or config write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall per item, one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 5);
            if (hold_req) begin
                hold_req = 0;
                gap = 300;
            end
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // one input item; valid stays high across back-to-back items
    task automatic send(input logic [11:0] a, input logic [11:0] b,
                        input logic [11:0] c, input logic chg);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {4'b0, c, b, a};
        s_axis_tuser <= chg;
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // three samples spread a little around an mV level
    task automatic send_level(input int lv, input logic chg);
        int s [3];
        foreach (s[k]) begin
            s[k] = lv + $urandom_range(0, 6) - 3;
            if (s[k] < 0) s[k] = 0;
            if (s[k] > 4095) s[k] = 4095;
        end
        // an occasional spike that the median pick must drop
        if ($urandom_range(0, 7) == 0) s[$urandom_range(0, 2)] = $urandom_range(0, 4095);
        send(12'(s[0]), 12'(s[1]), 12'(s[2]), chg);
    endtask

    task automatic settle;
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[6:0];
        @(negedge i_clk);
    endtask

    task automatic write_all(input int conf, input int thr, input int tol,
                             input int e, input int l, input int n, input int f,
                             input int h);
        write_reg(bgs_pkg::CfgConfirm, conf);
        write_reg(bgs_pkg::CfgJumpThr, thr);
        write_reg(bgs_pkg::CfgJumpTol, tol);
        write_reg(bgs_pkg::CfgEmpty, e);
        write_reg(bgs_pkg::CfgLow, l);
        write_reg(bgs_pkg::CfgNormal, n);
        write_reg(bgs_pkg::CfgFair, f);
        write_reg(bgs_pkg::CfgHigh, h);
        i_cfg_we <= 0;
    endtask

    initial begin
        bit chg;
        int lim [5];
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        calm = 0;
        hold_req = 0;
        idle_cycles = 0;
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: first reading seeds shown, then table edges and corners
        send_level(1800, 1'b0);
        send(12'd0, 12'd0, 12'd0, 1'b0);            // below the table
        send(12'hfff, 12'hfff, 12'hfff, 1'b0);      // above the table
        send(12'hfff, 12'd0, 12'd1500, 1'b0);       // median of extremes
        send(12'd1500, 12'd1500, 12'd1500, 1'b0);
        send(12'd2100, 12'd2100, 12'd2100, 1'b1);   // top corner, charging
        send(12'd2100, 12'd2100, 12'd2100, 1'b1);   // skipped phase
        send(12'd2075, 12'd2075, 12'd2075, 1'b1);
        send(12'd2075, 12'd2075, 12'd2075, 1'b1);
        send(12'd2050, 12'd2050, 12'd2050, 1'b0);
        send(12'd2050, 12'd2050, 12'd2050, 1'b0);   // confirmed jump
        send(12'd1650, 12'd1650, 12'd1650, 1'b0);
        send(12'd1651, 12'd1650, 12'd1649, 1'b0);
        for (int i = 0; i < 6; i++) send_level(1750 + 10 * i, 1'b1);  // climb while charging
        for (int i = 0; i < 4; i++) send_level(1640, 1'b0);           // slow decline
        settle();

        // confirm count zero, tightest jump settings, limits at the low end
        write_all(0, 1, 0, 0, 0, 0, 0, 0);
        level = 1800;
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 2) hold_req = 1;
            for (int i = 0; i < 100; i++) begin
                calm = (i >= 40 && i < 55);
                if ($urandom_range(0, 9) == 0) chg = ~chg;
                if ($urandom_range(0, 4) == 0) begin
                    send(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                         12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
                end else begin
                    if ($urandom_range(0, 15) == 0)
                        level = level + $urandom_range(0, 600) - 300;
                    else
                        level = level + $urandom_range(0, 4) - 2;
                    if (level < 1400) level = 1400;
                    if (level > 2200) level = 2200;
                    send_level(level, chg);
                end
            end
            calm = 0;
            settle();
            case (phase)
                0: write_all(15, 100, 100, 100, 100, 100, 100, 100);
                1: write_all(3, 5, 1, 5, 30, 45, 65, 85);
                2: write_all(1, 127, 127, 127, 127, 127, 127, 127);
                default: begin
                    foreach (lim[k]) lim[k] = $urandom_range(0, 100);
                    lim.sort();
                    write_all($urandom_range(0, 15), $urandom_range(1, 20),
                              $urandom_range(0, 5), lim[0], lim[1], lim[2], lim[3],
                              lim[4]);
                end
            endcase
        end

        settle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
